[rtl/rld_pkg.sv]
// record length detector: shared constants, control word types and microcode program
// no dependencies
`default_nettype none

package rld_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 2048;
  localparam int unsigned POS_BITS_DEF      = 32;

  localparam int unsigned MAX_RECORD = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned KW         = 11;
  localparam int unsigned NUM_VALUES = 256;
  localparam int unsigned ARCH_N     = 3;
  localparam int unsigned DIV_BITS   = 3;

  localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(32);
  localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(12);

  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_GAPS   = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_DIV0   = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_DIV1   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_DIV2   = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_DECIDE = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_RDMISS = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_MISS   = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_ROW2   = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_ROW3   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_EMIT   = STEP_W'(10);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_GAPS,
    OP_DIV,
    OP_DECIDE,
    OP_MISS,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_5R,
    RD_6R,
    RD_L1,
    RD_L,
    RD_2L,
    RD_3L
  } rd_e;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_M5,
    CAP_M6,
    CAP_ROW1,
    CAP_ROW2
  } cap_e;

  typedef enum logic [1:0] {
    JMP_ALWAYS,
    JMP_IF_IN,
    JMP_IF_OUT
  } jmp_e;

  typedef struct packed {
    op_e               op;
    rd_e               rd;
    cap_e              cap;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NONE, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_ALWAYS, target: ST_IDLE};
    unique case (step)
      ST_IDLE:   w = '{op: OP_ACCEPT, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_IF_IN,
                       target: ST_GAPS};
      ST_GAPS:   w = '{op: OP_GAPS, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_DIV0};
      ST_DIV0:   w = '{op: OP_DIV, rd: RD_5R, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_DIV1};
      ST_DIV1:   w = '{op: OP_DIV, rd: RD_6R, cap: CAP_M5, jmp: JMP_ALWAYS,
                       target: ST_DIV2};
      ST_DIV2:   w = '{op: OP_DIV, rd: RD_NONE, cap: CAP_M6, jmp: JMP_ALWAYS,
                       target: ST_DECIDE};
      ST_DECIDE: w = '{op: OP_DECIDE, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_RDMISS};
      ST_RDMISS: w = '{op: OP_NONE, rd: RD_L1, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_MISS};
      ST_MISS:   w = '{op: OP_MISS, rd: RD_L, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_ROW2};
      ST_ROW2:   w = '{op: OP_NONE, rd: RD_2L, cap: CAP_ROW1, jmp: JMP_ALWAYS,
                       target: ST_ROW3};
      ST_ROW3:   w = '{op: OP_NONE, rd: RD_3L, cap: CAP_ROW2, jmp: JMP_ALWAYS,
                       target: ST_EMIT};
      ST_EMIT:   w = '{op: OP_EMIT, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_IF_OUT,
                       target: ST_IDLE};
      default:   w = '{op: OP_NONE, rd: RD_NONE, cap: CAP_NONE, jmp: JMP_ALWAYS,
                       target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/rld_if.sv]
// record length detector: input and output channel interfaces
// depends on rld_pkg
`default_nettype none

interface rld_in_if;
  import rld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rld_out_if;
  import rld_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  record_length;
  logic              record_valid;
  logic [BYTE_W-1:0] one_row_back;
  logic [BYTE_W-1:0] two_rows_back;
  logic [BYTE_W-1:0] three_rows_back;
  modport source (output valid, output record_length, output record_valid,
                  output one_row_back, output two_rows_back, output three_rows_back,
                  input ready);
  modport sink (input valid, input record_length, input record_valid,
                input one_row_back, input two_rows_back, input three_rows_back,
                output ready);
endinterface

`default_nettype wire

[rtl/record_length_detector.sv]
// record length detector: top level, datapath around the microcode sequencer
// depends on rld_pkg, rld_if, rld_ram, rld_seq
//
// Takes one stream byte per item and returns one item with the current record
// length, its valid flag and the bytes one, two and three records back. Each
// byte is worked by an 11-step microcode program that drives the datapath, with
// six reads of the single byte history read port per byte and a three-step
// remainder unit that retires three quotient bits a cycle. A new byte is taken
// only in the program's idle step; the result waits in an output register and
// the program holds in its last step while that register is still full. Both
// stores come out of reset ready for use with no clearing pass: the per-value
// position table has one valid bit per byte value and the history has a fill
// count.
`default_nettype none

module record_length_detector #(
  parameter int unsigned HISTORY_DEPTH = rld_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned POS_BITS      = rld_pkg::POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rld_in_if.sink    in_i,
  rld_out_if.source out_o
);
  import rld_pkg::*;

  localparam int unsigned HIDX   = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W = HIDX + 1;
  localparam int unsigned TBL_W  = 4 * POS_BITS;
  localparam int unsigned VAL_W  = $clog2(NUM_VALUES);

  ucode_t uc;
  logic   in_fire, out_fire, out_free;

  // control state
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [NUM_VALUES-1:0] seen_q;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                lvalid_q, lvalid_d;
  logic [LEN_W-1:0]    miss_q, miss_d;
  logic [LEN_W-1:0]    arch_q [ARCH_N];
  logic [LEN_W-1:0]    arch_d [ARCH_N];
  logic                out_valid_q;

  // payload registers
  logic [BYTE_W-1:0] c_q;
  logic              tbl_ok_q, hist_ok_q;
  logic [LEN_W-1:0]  r9_q;
  logic              inrange_q, even_q, g34_q;
  logic [LEN_W-1:0]  rem_q, dvd_q, rem_d, dvd_d;
  logic [BYTE_W-1:0] m5_q, m6_q, row1_q, row2_q;
  logic [LEN_W-1:0]  o_len_q;
  logic              o_rvalid_q;
  logic [BYTE_W-1:0] o_row1_q, o_row2_q, o_row3_q;

  // memories
  logic [BYTE_W-1:0] hist_rdata, hist_data, row_data;
  logic [HIDX-1:0]   hist_idx;
  logic [KW-1:0]     back_k;
  logic              hist_re;
  logic [TBL_W-1:0]  tbl_rdata, tbl_row, tbl_wdata;
  logic [POS_BITS-1:0] last_p, second_p, third_p, fourth_p, r_d;

  // decision terms
  logic newlen, archived, long_ok, short_ok, upd;
  logic [LEN_W-1:0] miss_inc;

  rld_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .uc_o       (uc)
  );

  assign in_i.ready = (uc.op == OP_ACCEPT);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // byte history
  always_comb begin
    unique case (uc.rd)
      RD_NONE: back_k = '0;
      RD_5R:   back_k = (KW'(r9_q) << 2) + KW'(r9_q) + KW'(1);
      RD_6R:   back_k = (KW'(r9_q) << 2) + (KW'(r9_q) << 1) + KW'(1);
      RD_L1:   back_k = KW'(len_q) + KW'(1);
      RD_L:    back_k = KW'(len_q);
      RD_2L:   back_k = KW'(len_q) << 1;
      RD_3L:   back_k = (KW'(len_q) << 1) + KW'(len_q);
      default: back_k = '0;
    endcase
  end

  assign hist_idx  = pos_q[HIDX-1:0] - HIDX'(back_k);
  assign hist_re   = (uc.rd != RD_NONE);
  assign hist_data = hist_ok_q ? hist_rdata : '0;
  assign row_data  = (len_q == '0) ? '0 : hist_data;

  rld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (pos_q[HIDX-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (hist_re),
    .raddr_i (hist_idx),
    .rdata_o (hist_rdata)
  );

  // last four positions per byte value
  assign tbl_row   = tbl_ok_q ? tbl_rdata : '0;
  assign last_p    = tbl_row[0 +: POS_BITS];
  assign second_p  = tbl_row[POS_BITS +: POS_BITS];
  assign third_p   = tbl_row[2*POS_BITS +: POS_BITS];
  assign fourth_p  = tbl_row[3*POS_BITS +: POS_BITS];
  assign tbl_wdata = {third_p, second_p, last_p, pos_q};
  assign r_d       = pos_q - last_p;

  rld_ram #(
    .WIDTH (TBL_W),
    .DEPTH (NUM_VALUES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (uc.op == OP_GAPS),
    .waddr_i (VAL_W'(c_q)),
    .wdata_i (tbl_wdata),
    .re_i    (in_fire),
    .raddr_i (VAL_W'(in_i.data_byte)),
    .rdata_o (tbl_rdata)
  );

  // remainder unit, three bits a step
  always_comb begin
    logic [LEN_W:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {rem_d, dvd_d[LEN_W-1]};
      if (t >= {1'b0, len_q}) begin
        t = t - {1'b0, len_q};
      end
      rem_d = t[LEN_W-1:0];
      dvd_d = {dvd_d[LEN_W-2:0], 1'b0};
    end
  end

  // length decision and miss tracking
  always_comb begin
    newlen   = !lvalid_q || (len_q == '0) || (r9_q < len_q) || (rem_q != '0);
    archived = (r9_q == arch_q[0]) || (r9_q == arch_q[1]) || (r9_q == arch_q[2]);
    long_ok  = (r9_q >= LONG_LEN) || g34_q;
    short_ok = (r9_q >= SHORT_LEN) || ((c_q == m5_q) && (c_q == m6_q));
    upd      = inrange_q && newlen && even_q && (archived || (long_ok && short_ok));
    miss_inc = miss_q + LEN_W'(1);

    len_d    = len_q;
    lvalid_d = lvalid_q;
    miss_d   = miss_q;
    arch_d   = arch_q;

    if (uc.op == OP_DECIDE) begin
      if (upd) begin
        len_d    = r9_q;
        lvalid_d = 1'b1;
        miss_d   = '0;
        if (arch_q[0] != r9_q) begin
          if (arch_q[1] != r9_q) begin
            arch_d[2] = arch_q[1];
          end
          arch_d[1] = arch_q[0];
          arch_d[0] = r9_q;
        end
      end
    end else if (uc.op == OP_MISS) begin
      if (lvalid_q) begin
        if (hist_data == c_q) begin
          miss_d = miss_q >> 1;
        end else if (miss_inc >= len_q) begin
          lvalid_d = 1'b0;
          miss_d   = '0;
        end else begin
          miss_d = miss_inc;
        end
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (in_fire) begin
      pos_d = pos_q + POS_BITS'(1);
      if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      seen_q      <= '0;
      len_q       <= '0;
      lvalid_q    <= 1'b0;
      miss_q      <= '0;
      arch_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      lvalid_q <= lvalid_d;
      miss_q   <= miss_d;
      arch_q   <= arch_d;
      if (uc.op == OP_GAPS) begin
        seen_q[c_q] <= 1'b1;
      end
      if ((uc.op == OP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      c_q      <= in_i.data_byte;
      tbl_ok_q <= seen_q[in_i.data_byte];
    end
    if (hist_re) begin
      hist_ok_q <= ({1'b0, hist_idx} < fill_q);
    end
    if (uc.op == OP_GAPS) begin
      r9_q      <= r_d[LEN_W-1:0];
      inrange_q <= (r_d > POS_BITS'(1)) && (r_d <= POS_BITS'(MAX_RECORD));
      even_q    <= (r_d == last_p - second_p) && (r_d == second_p - third_p);
      g34_q     <= (r_d == third_p - fourth_p);
      rem_q     <= '0;
      dvd_q     <= r_d[LEN_W-1:0];
    end
    if (uc.op == OP_DIV) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
    unique case (uc.cap)
      CAP_NONE: ;
      CAP_M5:   m5_q   <= hist_data;
      CAP_M6:   m6_q   <= hist_data;
      CAP_ROW1: row1_q <= row_data;
      CAP_ROW2: row2_q <= row_data;
      default:  ;
    endcase
    if ((uc.op == OP_EMIT) && out_free) begin
      o_len_q    <= len_q;
      o_rvalid_q <= lvalid_q;
      o_row1_q   <= row1_q;
      o_row2_q   <= row2_q;
      o_row3_q   <= row_data;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.record_length   = o_len_q;
  assign out_o.record_valid    = o_rvalid_q;
  assign out_o.one_row_back    = o_row1_q;
  assign out_o.two_rows_back   = o_row2_q;
  assign out_o.three_rows_back = o_row3_q;

  // one byte in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("byte accepted while previous one still in work");

  // miss count stays below the length while valid, cleared otherwise
  a_miss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvalid_q ? (miss_q < len_q) : (miss_q == '0))
    else $error("miss count out of range");

  // the newest archive entry always holds the current length
  a_arch_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (arch_q[0] == len_q))
    else $error("archive head differs from current length");

  // a valid length is at least two
  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvalid_q |-> (len_q >= LEN_W'(2)))
    else $error("valid length below two");

endmodule

`default_nettype wire

[rtl/rld_ram.sv]
// record length detector: generic ram, one write port, one registered read port
// depends on rld_pkg for defaults
`default_nettype none

module rld_ram #(
  parameter int unsigned WIDTH = rld_pkg::BYTE_W,
  parameter int unsigned DEPTH = rld_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/rld_seq.sv]
// record length detector: microcode sequencer, step counter and program rom
// depends on rld_pkg
`default_nettype none

module rld_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  output rld_pkg::ucode_t uc_o
);
  import rld_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              taken;

  assign uc_o = ucode_rom(step_q);

  always_comb begin
    unique case (uc_o.jmp)
      JMP_ALWAYS: taken = 1'b1;
      JMP_IF_IN:  taken = in_fire_i;
      JMP_IF_OUT: taken = out_free_i;
      default:    taken = 1'b0;
    endcase
    step_d = taken ? uc_o.target : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

[test/tb.sv]
// record length detector testbench: drives random byte streams with records,
// checks every result against a cycle-free model of the detector
// depends on rld_pkg, rld_if and record_length_detector

module tb;
  import rld_pkg::*;

  localparam logic [31:0] HIST_MASK = HISTORY_DEPTH_DEF - 1;
  localparam int unsigned N_ITEMS   = 500;

  typedef struct packed {
    logic [LEN_W-1:0]  record_length;
    logic              record_valid;
    logic [BYTE_W-1:0] one_row_back;
    logic [BYTE_W-1:0] two_rows_back;
    logic [BYTE_W-1:0] three_rows_back;
  } row_t;

  class row_checker;
    logic [BYTE_W-1:0] hist [HISTORY_DEPTH_DEF];
    logic [31:0]       pos;
    logic [31:0]       seen [4][NUM_VALUES];
    logic [LEN_W-1:0]  archive [ARCH_N];
    logic [LEN_W-1:0]  cur_len;
    logic              len_ok;
    logic [LEN_W-1:0]  misses;
    row_t              expected_rows [$];
    int unsigned       errors;
    int unsigned       rows_checked;
    int unsigned       length_changes;
    int unsigned       validity_losses;
    logic [LEN_W-1:0]  longest;

    function new();
      foreach (hist[i]) hist[i] = '0;
      foreach (seen[i, j]) seen[i][j] = '0;
      foreach (archive[i]) archive[i] = '0;
      pos = '0;
      cur_len = '0;
      len_ok = 1'b0;
      misses = '0;
      errors = 0;
      rows_checked = 0;
      length_changes = 0;
      validity_losses = 0;
      longest = '0;
    endfunction

    function logic [BYTE_W-1:0] back(logic [31:0] k);
      logic [31:0] idx;
      idx = (pos - k) & HIST_MASK;
      return hist[idx];
    endfunction

    function void take_byte(logic [BYTE_W-1:0] c);
      logic [31:0] r;
      logic [31:0] len32;
      bit          retry, spaced, archived, long_ok, short_ok;
      row_t        want;
      hist[pos & HIST_MASK] = c;
      pos = pos + 1;
      r = pos - seen[0][c];
      len32 = 32'(cur_len);
      retry = !len_ok || cur_len == 0 || r < len32 || (r % len32) != 0;
      if (r > 1 && r <= MAX_RECORD && retry) begin
        spaced = r == seen[0][c] - seen[1][c] && r == seen[1][c] - seen[2][c];
        if (spaced) begin
          archived = r == 32'(archive[0]) || r == 32'(archive[1]) ||
                     r == 32'(archive[2]);
          long_ok = r >= 32'(LONG_LEN) || r == seen[2][c] - seen[3][c];
          short_ok = r >= 32'(SHORT_LEN) ||
                     (c == back(r * 5 + 1) && c == back(r * 6 + 1));
          if (archived || (long_ok && short_ok)) begin
            if (r[LEN_W-1:0] != cur_len) length_changes++;
            cur_len = r[LEN_W-1:0];
            if (cur_len > longest) longest = cur_len;
            len_ok = 1'b1;
            misses = '0;
            if (archive[0] != r[LEN_W-1:0]) begin
              if (archive[1] != r[LEN_W-1:0]) archive[2] = archive[1];
              archive[1] = archive[0];
              archive[0] = r[LEN_W-1:0];
            end
          end
        end
      end
      len32 = 32'(cur_len);
      if (len_ok) begin
        if (back(len32 + 1) == c) begin
          misses = misses >> 1;
        end else begin
          misses = misses + 1'b1;
          if (misses >= cur_len) begin
            len_ok = 1'b0;
            misses = '0;
            validity_losses++;
          end
        end
      end
      seen[3][c] = seen[2][c];
      seen[2][c] = seen[1][c];
      seen[1][c] = seen[0][c];
      seen[0][c] = pos;
      want.record_length = cur_len;
      want.record_valid = len_ok;
      if (cur_len == 0) begin
        want.one_row_back = '0;
        want.two_rows_back = '0;
        want.three_rows_back = '0;
      end else begin
        want.one_row_back = back(len32);
        want.two_rows_back = back(len32 * 2);
        want.three_rows_back = back(len32 * 3);
      end
      expected_rows.push_back(want);
    endfunction

    function void check_row(row_t got);
      row_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected row: len %0d valid %0d rows %02h %02h %02h",
                   got.record_length, got.record_valid, got.one_row_back,
                   got.two_rows_back, got.three_rows_back);
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.record_length !== want.record_length ||
          got.record_valid !== want.record_valid ||
          got.one_row_back !== want.one_row_back ||
          got.two_rows_back !== want.two_rows_back ||
          got.three_rows_back !== want.three_rows_back) begin
        errors++;
        if (errors <= 10)
          $display({"row %0d: expected len %0d valid %0d rows %02h %02h %02h,",
                    " got len %0d valid %0d rows %02h %02h %02h"},
                   rows_checked, want.record_length, want.record_valid,
                   want.one_row_back, want.two_rows_back, want.three_rows_back,
                   got.record_length, got.record_valid, got.one_row_back,
                   got.two_rows_back, got.three_rows_back);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rld_in_if  in_if ();
  rld_out_if out_if ();
  row_checker  sb;
  int unsigned bytes_sent;
  int unsigned rows_taken;

  record_length_detector uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("record_length_detector: mismatch");
    $finish;
  end

  // idle-free stretches of 40 items in every 160 items
  function automatic int unsigned draw_pause(int unsigned idx);
    if ((idx / 40) % 4 == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned pause;
    pause = draw_pause(bytes_sent);
    @(negedge clk);
    if (pause > 0) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= BYTE_W'($urandom);
      repeat (pause) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic play_records(input int unsigned len, input int unsigned reps,
                              input int unsigned corrupt_pct);
    logic [BYTE_W-1:0] rec [MAX_RECORD];
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) rec[i] = BYTE_W'($urandom_range(0, 255));
    repeat (reps) begin
      for (int i = 0; i < len; i++) begin
        b = rec[i];
        if ($urandom_range(0, 99) < corrupt_pct) b = BYTE_W'($urandom_range(0, 255));
        push_byte(b);
      end
    end
  endtask

  task automatic take_rows();
    int unsigned pause;
    row_t        got;
    forever begin
      // one long hold-off so the block fills up and stalls its input
      pause = (rows_taken == 150) ? 400 : draw_pause(rows_taken);
      @(negedge clk);
      if (pause > 0) begin
        out_if.ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.record_length = out_if.record_length;
      got.record_valid = out_if.record_valid;
      got.one_row_back = out_if.one_row_back;
      got.two_rows_back = out_if.two_rows_back;
      got.three_rows_back = out_if.three_rows_back;
      sb.check_row(got);
      rows_taken++;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] directed [$];
    int unsigned       pick;
    int unsigned       len;
    int unsigned       reps;
    int unsigned       room;
    int unsigned       len_max;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    sb = new();
    bytes_sent = 0;
    rows_taken = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      take_rows();
    join_none

    // field extremes, a run of one value, then a short two-byte record
    directed = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80,
                 8'h7e, 8'h7e, 8'h7e};
    foreach (directed[i]) push_byte(directed[i]);
    play_records(2, 5, 0);

    // mostly records with random content, some noise and damaged records
    while (bytes_sent < N_ITEMS) begin
      room = N_ITEMS - bytes_sent;
      pick = $urandom_range(0, 99);
      if (pick < 15 || room < 8) begin
        repeat ($urandom_range(1, (room < 30) ? room : 30))
          push_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        reps = (pick < 65) ? $urandom_range(4, 8) : 4;
        len_max = room / reps;
        if (len_max < 2) len_max = 2;
        if (pick < 65 || len_max < 17) begin
          len = $urandom_range(2, (len_max < 16) ? len_max : 16);
        end else begin
          len = $urandom_range(17, (len_max < 120) ? len_max : 120);
        end
        play_records(len, reps, (pick < 30) ? $urandom_range(5, 30) : 0);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("sent %0d bytes, checked %0d rows", bytes_sent, sb.rows_checked);
    $display("saw %0d length changes up to %0d, %0d validity losses",
             sb.length_changes, sb.longest, sb.validity_losses);
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("record_length_detector: match");
    end else begin
      $display("%0d bad rows", sb.errors);
      $display("record_length_detector: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rld_pkg.sv
rtl/rld_if.sv
rtl/rld_ram.sv
rtl/rld_seq.sv
rtl/record_length_detector.sv
test/tb.sv
